[rtl/river_cell_flow_routing_defines.svh]
// ----------------------------------------------------------------------------
// river cell flow routing assertion macros
// shared property forms for the routing block checks
// ----------------------------------------------------------------------------
`ifndef RIVER_CELL_FLOW_ROUTING_DEFINES_SVH
`define RIVER_CELL_FLOW_ROUTING_DEFINES_SVH

// same-cycle implication
`define RCFR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RCFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/rcfr_pkg.sv]
// ----------------------------------------------------------------------------
// rcfr_pkg
// widths, payload types and saturation helper for the river cell routing block
// ----------------------------------------------------------------------------
package rcfr_pkg;

    localparam int CELLS_DEF   = 4096;
    localparam int CELL_W      = 12;
    localparam int FLOW_W      = 32;
    localparam int ABS_W       = 31;
    localparam int COEF_W      = 16;
    localparam int COEF_FRAC   = 15;
    localparam int STATE_W     = 2 * FLOW_W;
    localparam int RECIP_SHIFT = 24;

    typedef logic [CELL_W-1:0]        cell_t;
    typedef logic signed [FLOW_W-1:0] flow_t;
    typedef logic [ABS_W-1:0]         abs_t;
    typedef logic [COEF_W-1:0]        coef_t;

    typedef struct packed {
        cell_t cell_id;
        flow_t upstream;
        flow_t runoff;
        abs_t  demand;
        coef_t c_now;
        coef_t c_prev;
        coef_t c_out;
        logic  coefs_valid;
        logic  has_reservoir;
        flow_t rel_flow;
        logic  obs_valid;
        flow_t obs;
    } req_t;

    typedef struct packed {
        cell_t cell_id;
        logic  coefs_valid;
        logic  has_reservoir;
        flow_t rel_flow;
        logic  obs_valid;
        flow_t obs;
        flow_t inflow;
        flow_t prev_in;
        abs_t  taken;
        abs_t  excess;
    } ctx_t;

    function automatic flow_t sat_flow(input logic signed [FLOW_W:0] v);
        flow_t r;
        if (v[FLOW_W] != v[FLOW_W-1]) begin
            r = v[FLOW_W] ? {1'b1, {(FLOW_W-1){1'b0}}} : {1'b0, {(FLOW_W-1){1'b1}}};
        end else begin
            r = v[FLOW_W-1:0];
        end
        return r;
    endfunction

endpackage

[rtl/rcfr_ram.sv]
// ----------------------------------------------------------------------------
// rcfr_ram
// simple dual-port ram, one write port, one registered read port with enable
// ----------------------------------------------------------------------------
module rcfr_ram import rcfr_pkg::*; #(
    parameter int WIDTH = STATE_W,
    parameter int DEPTH = CELLS_DEF,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/river_cell_flow_routing.sv]
// ----------------------------------------------------------------------------
// river_cell_flow_routing
// per-cell muskingum routing step with abstraction, reservoir release and
// observation override; cell state kept in one ram
// ----------------------------------------------------------------------------
// One cell step is taken per cycle when no stall or hazard holds it; its
// result leaves through the output register. Each cell's previous inflow
// and outflow sit in one ram, read two stages before the multipliers and
// written back when the result is loaded; a step for a cell that still has
// an earlier step in the three stages past the read waits there until that
// write-back, which a stalled output delays.
// After reset a clearing pass zeroes the ram, and no input transfer is taken
// during it; configuration writes are taken throughout.
`include "river_cell_flow_routing_defines.svh"

module river_cell_flow_routing import rcfr_pkg::*; #(
    parameter int CELLS = CELLS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  cell_t       s_cell_req,
    input  flow_t       s_upstream_flow,
    input  flow_t       s_runoff_flow,
    input  abs_t        s_abstraction_flow,
    input  coef_t       s_coef_now,
    input  coef_t       s_coef_prev,
    input  coef_t       s_coef_out,
    input  logic        s_coefs_valid,
    input  logic        s_has_reservoir,
    input  flow_t       s_release_flow,
    input  logic        s_obs_valid,
    input  flow_t       s_obs_flow,

    output logic        m_valid,
    input  logic        m_ready,
    output cell_t       m_cell_out,
    output flow_t       m_routed_flow,
    output flow_t       m_calculated_flow,
    output abs_t        m_taken_abstraction,
    output abs_t        m_excess_abstraction,
    output flow_t       m_storage_change
);

    localparam int IDX_W  = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int PROD_W = FLOW_W + COEF_W + 1;
    localparam int SUM_W  = PROD_W + 2;
    localparam int Q_W    = SUM_W - COEF_FRAC;
    localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (COEF_FRAC - 1);

    // configuration
    logic corr_en_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            corr_en_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            corr_en_reg <= cfg_wr_data;
        end
    end

    // clearing pass
    logic             clr_active_reg;
    logic [IDX_W-1:0] clr_addr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end else if (clr_active_reg) begin
            clr_addr_reg <= clr_addr_reg + IDX_W'(1);
            if (clr_addr_reg == IDX_W'(CELLS - 1)) begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    // pipeline control
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, m_valid_reg;
    logic s1_move, s2_move, s3_move, s4_move, s_accept, hazard;
    logic [IDX_W-1:0] idx1, s2_idx_reg, s3_idx_reg, s4_idx_reg;

    assign s4_move  = s4_valid_reg && (!m_valid_reg || m_ready);
    assign s3_move  = s3_valid_reg && (!s4_valid_reg || s4_move);
    assign s2_move  = s2_valid_reg && (!s3_valid_reg || s3_move);
    assign hazard   = (s2_valid_reg && (s2_idx_reg == idx1))
                   || (s3_valid_reg && (s3_idx_reg == idx1))
                   || (s4_valid_reg && (s4_idx_reg == idx1));
    assign s1_move  = s1_valid_reg && !hazard && (!s2_valid_reg || s2_move);
    assign s_ready  = !clr_active_reg && (!s1_valid_reg || s1_move);
    assign s_accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_accept) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_move) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_move) begin
                s2_valid_reg <= 1'b1;
            end else if (s2_move) begin
                s2_valid_reg <= 1'b0;
            end
            if (s2_move) begin
                s3_valid_reg <= 1'b1;
            end else if (s3_move) begin
                s3_valid_reg <= 1'b0;
            end
            if (s3_move) begin
                s4_valid_reg <= 1'b1;
            end else if (s4_move) begin
                s4_valid_reg <= 1'b0;
            end
            if (s4_move) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // stage 1: input register and cell index
    req_t s1_reg, s2_reg, req_in;

    assign req_in = '{
        cell_id:       s_cell_req,
        upstream:      s_upstream_flow,
        runoff:        s_runoff_flow,
        demand:        s_abstraction_flow,
        c_now:         s_coef_now,
        c_prev:        s_coef_prev,
        c_out:         s_coef_out,
        coefs_valid:   s_coefs_valid,
        has_reservoir: s_has_reservoir,
        rel_flow:      s_release_flow,
        obs_valid:     s_obs_valid,
        obs:           s_obs_flow
    };

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_reg <= req_in;
        end
    end

    generate
        if (CELLS >= (1 << CELL_W)) begin : g_idx_direct
            assign idx1 = IDX_W'(s1_reg.cell_id);
        end else begin : g_idx_mod
            // quotient by reciprocal multiply, exact for all 12-bit indexes
            localparam int RECIP   = ((1 << RECIP_SHIFT) + CELLS - 1) / CELLS;
            localparam int RECIP_W = RECIP_SHIFT + 1;
            localparam int MP_W    = CELL_W + RECIP_W;
            logic [MP_W-1:0]   prod;
            logic [CELL_W-1:0] q_reg, qc, rem;

            assign prod = MP_W'(s_cell_req) * MP_W'(RECIP);

            always_ff @(posedge aclk) begin
                if (s_accept) begin
                    q_reg <= prod[RECIP_SHIFT +: CELL_W];
                end
            end

            assign qc   = CELL_W'(q_reg * CELL_W'(CELLS));
            assign rem  = s1_reg.cell_id - qc;
            assign idx1 = rem[IDX_W-1:0];
        end
    endgenerate

    // state ram
    logic               ram_wr_en;
    logic [IDX_W-1:0]   ram_wr_addr;
    logic [STATE_W-1:0] ram_wr_data, ram_rd_data, wb_data;

    assign ram_wr_en   = clr_active_reg || s4_move;
    assign ram_wr_addr = clr_active_reg ? clr_addr_reg : s4_idx_reg;
    assign ram_wr_data = clr_active_reg ? '0 : wb_data;

    rcfr_ram #(
        .WIDTH (STATE_W),
        .DEPTH (CELLS)
    ) u_state_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (s1_move),
        .rd_addr (idx1),
        .rd_data (ram_rd_data)
    );

    // stage 2: inflow and abstraction
    always_ff @(posedge aclk) begin
        if (s1_move) begin
            s2_reg     <= s1_reg;
            s2_idx_reg <= idx1;
        end
    end

    logic signed [FLOW_W:0] in_sum, dem_x, inf_x, exc_x;
    flow_t inflow_sat, prev_out2;
    logic  short_fall;
    ctx_t  ctx2, s3_ctx_reg, s4_ctx_reg;

    always_comb begin
        in_sum     = {s2_reg.upstream[FLOW_W-1], s2_reg.upstream}
                   + {s2_reg.runoff[FLOW_W-1], s2_reg.runoff};
        inflow_sat = sat_flow(in_sum);
        dem_x      = {2'b00, s2_reg.demand};
        inf_x      = {inflow_sat[FLOW_W-1], inflow_sat};
        short_fall = dem_x > inf_x;
        exc_x      = dem_x - inf_x;
        prev_out2  = ram_rd_data[FLOW_W-1:0];

        ctx2.cell_id       = s2_reg.cell_id;
        ctx2.coefs_valid   = s2_reg.coefs_valid;
        ctx2.has_reservoir = s2_reg.has_reservoir;
        ctx2.rel_flow      = s2_reg.rel_flow;
        ctx2.obs_valid     = s2_reg.obs_valid;
        ctx2.obs           = s2_reg.obs;
        ctx2.prev_in       = ram_rd_data[STATE_W-1:FLOW_W];
        if (short_fall) begin
            ctx2.inflow = '0;
            ctx2.taken  = inflow_sat[FLOW_W-1] ? '0 : inflow_sat[ABS_W-1:0];
            ctx2.excess = (exc_x[FLOW_W:ABS_W] != '0) ? '1 : exc_x[ABS_W-1:0];
        end else begin
            ctx2.inflow = inflow_sat;
            ctx2.taken  = s2_reg.demand;
            ctx2.excess = '0;
        end
    end

    // stage 3: products
    coef_t s3_c_now_reg, s3_c_prev_reg, s3_c_out_reg;
    flow_t s3_prev_out_reg;

    always_ff @(posedge aclk) begin
        if (s2_move) begin
            s3_ctx_reg      <= ctx2;
            s3_idx_reg      <= s2_idx_reg;
            s3_prev_out_reg <= prev_out2;
            s3_c_now_reg    <= s2_reg.c_now;
            s3_c_prev_reg   <= s2_reg.c_prev;
            s3_c_out_reg    <= s2_reg.c_out;
        end
    end

    logic signed [PROD_W-1:0] p_now, p_prev, p_out;
    logic signed [PROD_W-1:0] s4_p_now_reg, s4_p_prev_reg, s4_p_out_reg;

    assign p_now  = $signed({1'b0, s3_c_now_reg})  * s3_ctx_reg.inflow;
    assign p_prev = $signed({1'b0, s3_c_prev_reg}) * s3_ctx_reg.prev_in;
    assign p_out  = $signed({1'b0, s3_c_out_reg})  * s3_prev_out_reg;

    always_ff @(posedge aclk) begin
        if (s3_move) begin
            s4_ctx_reg    <= s3_ctx_reg;
            s4_idx_reg    <= s3_idx_reg;
            s4_p_now_reg  <= p_now;
            s4_p_prev_reg <= p_prev;
            s4_p_out_reg  <= p_out;
        end
    end

    // stage 4: sum, round, saturate, write back
    logic signed [SUM_W-1:0] rsum;
    logic signed [Q_W-1:0]   qsum;
    logic [Q_W-FLOW_W:0]     qhi;
    logic signed [FLOW_W:0]  chg_x;
    flow_t musk, outflow, routed, chg;

    always_comb begin
        rsum  = SUM_W'(s4_p_now_reg) + SUM_W'(s4_p_prev_reg) + SUM_W'(s4_p_out_reg)
              + ROUND_HALF;
        qsum  = rsum[SUM_W-1:COEF_FRAC];
        qhi   = qsum[Q_W-1:FLOW_W-1];
        if ((&qhi) || !(|qhi)) begin
            musk = qsum[FLOW_W-1:0];
        end else begin
            musk = qsum[Q_W-1] ? {1'b1, {(FLOW_W-1){1'b0}}} : {1'b0, {(FLOW_W-1){1'b1}}};
        end
        outflow = s4_ctx_reg.has_reservoir ? s4_ctx_reg.rel_flow : musk;
        routed  = (corr_en_reg && s4_ctx_reg.obs_valid) ? s4_ctx_reg.obs : outflow;
        chg_x   = {s4_ctx_reg.prev_in[FLOW_W-1], s4_ctx_reg.prev_in}
                - {outflow[FLOW_W-1], outflow};
        chg     = sat_flow(chg_x);
        wb_data = s4_ctx_reg.coefs_valid ? {s4_ctx_reg.inflow, outflow} : '0;
    end

    // output register
    cell_t m_cell_reg;
    flow_t m_routed_reg, m_calc_reg, m_chg_reg;
    abs_t  m_taken_reg, m_excess_reg;

    always_ff @(posedge aclk) begin
        if (s4_move) begin
            m_cell_reg <= s4_ctx_reg.cell_id;
            if (s4_ctx_reg.coefs_valid) begin
                m_routed_reg <= routed;
                m_calc_reg   <= outflow;
                m_taken_reg  <= s4_ctx_reg.taken;
                m_excess_reg <= s4_ctx_reg.excess;
                m_chg_reg    <= chg;
            end else begin
                m_routed_reg <= '0;
                m_calc_reg   <= '0;
                m_taken_reg  <= '0;
                m_excess_reg <= '0;
                m_chg_reg    <= '0;
            end
        end
    end

    assign m_valid              = m_valid_reg;
    assign m_cell_out           = m_cell_reg;
    assign m_routed_flow        = m_routed_reg;
    assign m_calculated_flow    = m_calc_reg;
    assign m_taken_abstraction  = m_taken_reg;
    assign m_excess_abstraction = m_excess_reg;
    assign m_storage_change     = m_chg_reg;

    // checks
    `RCFR_ASSERT_NOW(a_no_transfer_in_clear, aclk, aresetn, clr_active_reg, !s_ready,
                     "input taken during clearing pass")
    `RCFR_ASSERT_NEXT(a_clear_once, aclk, aresetn, !clr_active_reg, !clr_active_reg,
                      "clearing pass restarted")
    `RCFR_ASSERT_NOW(a_wb_no_pending_read, aclk, aresetn, s4_move && s2_valid_reg,
                     s2_idx_reg != s4_idx_reg, "write-back hits a cell already read")

endmodule
